FILE: hdl/ifrt_pkg.sv
// Package for the IPv4 fragment reassembly tracker.
// Shared types and fixed constants; no dependencies.
package ifrt_pkg;

    localparam int unsigned SLOT_COUNT = 4;

    localparam int unsigned ID_W    = 16;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned MAP_W   = 32;
    localparam int unsigned LEN_W   = 14;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_DISCARD = 2'd3;

    localparam logic FUNC_FRAG  = 1'b0;
    localparam logic FUNC_SWEEP = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_CHECK,
        S_EMIT
    } ctrl_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;     // capture the request
        logic scan;     // examine slot at scan pointer
        logic apply;    // open/update chosen slot
        logic check;    // completion check
        logic emit;     // load output register
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_last;  // scan pointer at last slot
        logic early;      // result settled at load, no scan needed
    } dp_stat_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        slot_index;
        logic [WORD_W-1:0] datagram_len;
        logic              unfragmented;
        logic [2:0]        reaped_count;
    } result_t;

endpackage

FILE: hdl/ifrt_if.sv
// Valid/ready channel interfaces for the tracker.
// Has no dependencies.
interface ifrt_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [31:0]                   now_time;
    logic [15:0]                   frag_id;
    logic [31:0]                   src_addr;
    logic [15:0]                   frag_word;
    logic [15:0]                   ip_total_len;
    logic [15:0]                   packet_len;

    modport source (output valid, func, now_time, frag_id, src_addr, frag_word,
                    ip_total_len, packet_len, input ready);
    modport sink   (input valid, func, now_time, frag_id, src_addr, frag_word,
                    ip_total_len, packet_len, output ready);
endinterface

interface ifrt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  slot_index;
    logic [15:0] datagram_len;
    logic        unfragmented;
    logic [2:0]  reaped_count;

    modport source (output valid, status, slot_index, datagram_len, unfragmented,
                    reaped_count, input ready);
    modport sink   (input valid, status, slot_index, datagram_len, unfragmented,
                    reaped_count, output ready);
endinterface

FILE: hdl/ifrt_ctrl.sv
// Controller state machine for the tracker.
// Depends on ifrt_pkg.
module ifrt_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    out_busy,
    input  ifrt_pkg::dp_stat_t      stat,
    output ifrt_pkg::dp_cmd_t       cmd
);
    import ifrt_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_SCAN;
            S_SCAN:  if (stat.early) state_next = S_EMIT;
                     else if (stat.scan_last) state_next = S_APPLY;
            S_APPLY: state_next = S_CHECK;
            S_CHECK: state_next = S_EMIT;
            S_EMIT:  if (!out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN:  cmd.scan = !stat.early;
            S_APPLY: cmd.apply = 1'b1;
            S_CHECK: cmd.check = 1'b1;
            S_EMIT:  cmd.emit = !out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

FILE: hdl/ifrt_dp.sv
// Datapath for the tracker: slot table, request registers, scan and result.
// Depends on ifrt_pkg.
module ifrt_dp
#(
    parameter int unsigned MAX_DATAGRAM = 8192,
    parameter int unsigned HEADER_BYTES = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ifrt_pkg::dp_cmd_t    cmd,
    output ifrt_pkg::dp_stat_t   stat,
    input  logic [31:0]          timeout_ms,
    input  logic                 func,
    input  logic [31:0]          now_time,
    input  logic [15:0]          frag_id,
    input  logic [31:0]          src_addr,
    input  logic [15:0]          frag_word,
    input  logic [15:0]          ip_total_len,
    input  logic [15:0]          packet_len,
    output ifrt_pkg::result_t    result
);
    import ifrt_pkg::*;

    localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [SLOT_COUNT-1:0] used_reg, done_reg;
    logic [ID_W-1:0]       ident_reg  [SLOT_COUNT];
    logic [ADDR_W-1:0]     source_reg [SLOT_COUNT];
    logic [TIME_W-1:0]     stamp_reg  [SLOT_COUNT];
    logic [MAP_W-1:0]      map_reg    [SLOT_COUNT];
    logic [LEN_W-1:0]      length_reg [SLOT_COUNT];

    // request fields
    logic              func_reg;
    logic [31:0]       now_reg;
    logic [15:0]       id_reg;
    logic [31:0]       src_reg;
    logic              more_reg;
    logic [15:0]       off_reg;
    logic [16:0]       end_reg;

    logic [SW-1:0]     ptr_reg;
    logic              found_reg, free_reg;
    logic [SW-1:0]     sel_reg, free_idx_reg, old_idx_reg;
    logic [31:0]       old_age_reg;
    logic [2:0]        reaped_reg;
    result_t           res_reg, res_next;
    logic              early_reg;

    // load decode
    logic [15:0] in_off;
    logic        in_more;
    always_comb
    begin
        in_off  = {frag_word[12:0], 3'b000};
        in_more = frag_word[13];
        res_next = '0;
        if (func == FUNC_SWEEP)
            res_next.status = ST_PENDING;
        else if (packet_len < 16'(HEADER_BYTES))
            res_next.status = ST_ERROR;
        else if (in_off == 16'd0 && !in_more)
        begin
            if (ip_total_len < 16'(HEADER_BYTES) || ip_total_len > packet_len)
                res_next.status = ST_ERROR;
            else
            begin
                res_next.status = ST_DONE;
                res_next.unfragmented = 1'b1;
                res_next.datagram_len = ip_total_len - 16'(HEADER_BYTES);
            end
        end
        else if (ip_total_len < 16'(HEADER_BYTES))
            res_next.status = ST_ERROR;
    end

    logic early_next;
    assign early_next = (func == FUNC_FRAG) && (res_next.status == ST_ERROR
        || res_next.unfragmented);

    // scan of one slot
    logic [SW-1:0] p;
    logic [31:0]   age;
    logic          hit;
    logic          last;
    always_comb
    begin
        p    = ptr_reg;
        age  = now_reg - stamp_reg[p];
        hit  = used_reg[p] && !done_reg[p] && ident_reg[p] == id_reg
               && source_reg[p] == src_reg;
        last = (ptr_reg == SW'(SLOT_COUNT - 1));
    end

    assign stat.scan_last = last;
    assign stat.early     = early_reg;

    // slot taken by the fragment: match, else first free, else oldest
    logic [SW-1:0] pick;
    assign pick = found_reg ? sel_reg : (free_reg ? free_idx_reg : old_idx_reg);

    // chunk mask for the fragment
    logic [MAP_W-1:0] frag_mask;
    logic [5:0]       c_lo;
    logic [8:0]       c_hi;
    always_comb
    begin
        c_lo = 6'(off_reg[15:8]);
        c_hi = 9'((end_reg + 17'd255) >> 8);
        for (int i = 0; i < MAP_W; i++)
            frag_mask[i] = (9'(i) >= 9'(c_lo)) && (9'(i) < c_hi);
    end

    // completion mask for selected slot
    logic [LEN_W-1:0] slen;
    logic [MAP_W-1:0] need;
    logic [6:0]       chunks;
    logic             full;
    always_comb
    begin
        slen   = length_reg[sel_reg];
        chunks = 7'((15'(slen) + 15'd255) >> 8);
        for (int i = 0; i < MAP_W; i++)
            need[i] = 7'(i) < chunks;
        full = (slen != '0) && (chunks <= 7'd32) && ((map_reg[sel_reg] & need) == need);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            done_reg <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                map_reg[i]    <= '0;
                length_reg[i] <= '0;
            end
            ptr_reg   <= '0;
            early_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ptr_reg   <= '0;
                early_reg <= early_next;
            end
            if (cmd.scan)
            begin
                ptr_reg <= last ? '0 : ptr_reg + 1'b1;
                if (func_reg == FUNC_SWEEP && used_reg[p]
                    && (done_reg[p] || age > timeout_ms))
                begin
                    used_reg[p]   <= 1'b0;
                    done_reg[p]   <= 1'b0;
                    map_reg[p]    <= '0;
                    length_reg[p] <= '0;
                end
            end
            if (cmd.apply && func_reg == FUNC_FRAG && (found_reg || off_reg == 16'd0))
            begin
                if (end_reg > 17'(MAX_DATAGRAM))
                begin
                    used_reg[pick]   <= 1'b0;
                    done_reg[pick]   <= 1'b0;
                    map_reg[pick]    <= '0;
                    length_reg[pick] <= '0;
                end
                else
                begin
                    used_reg[pick] <= 1'b1;
                    if (!found_reg)
                        done_reg[pick] <= 1'b0;
                    map_reg[pick] <= (found_reg ? map_reg[pick] : '0) | frag_mask;
                    if (!more_reg)
                        length_reg[pick] <= end_reg[LEN_W-1:0];
                    else if (!found_reg)
                        length_reg[pick] <= '0;
                end
            end
            if (cmd.check && func_reg == FUNC_FRAG && res_reg.status == ST_PENDING
                && full)
                done_reg[sel_reg] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            now_reg    <= now_time;
            id_reg     <= frag_id;
            src_reg    <= src_addr;
            more_reg   <= in_more;
            off_reg    <= in_off;
            end_reg    <= 17'(in_off) + 17'(ip_total_len - 16'(HEADER_BYTES));
            found_reg  <= 1'b0;
            free_reg   <= 1'b0;
            old_age_reg <= '0;
            old_idx_reg <= '0;
            free_idx_reg <= '0;
            reaped_reg <= '0;
            res_reg    <= res_next;
        end
        if (cmd.scan)
        begin
            if (func_reg == FUNC_SWEEP)
            begin
                if (used_reg[p] && (done_reg[p] || age > timeout_ms))
                    reaped_reg <= reaped_reg + 3'd1;
            end
            else
            begin
                if (hit && !found_reg)
                begin
                    found_reg <= 1'b1;
                    sel_reg   <= p;
                end
                if (!used_reg[p] && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= p;
                end
                if (p == '0 || age > old_age_reg)
                begin
                    old_age_reg <= age;
                    old_idx_reg <= p;
                end
            end
        end
        if (cmd.apply)
        begin
            if (func_reg == FUNC_SWEEP)
                res_reg.reaped_count <= reaped_reg;
            else if (!found_reg && off_reg != 16'd0)
                res_reg.status <= ST_DISCARD;
            else
            begin
                if (!found_reg)
                begin
                    sel_reg          <= pick;
                    stamp_reg[pick]  <= now_reg;
                    ident_reg[pick]  <= id_reg;
                    source_reg[pick] <= src_reg;
                end
                res_reg.slot_index <= 2'(pick);
                if (end_reg > 17'(MAX_DATAGRAM))
                    res_reg.status <= ST_ERROR;
            end
        end
        if (cmd.check && func_reg == FUNC_FRAG && res_reg.status == ST_PENDING && full)
        begin
            res_reg.status       <= ST_DONE;
            res_reg.datagram_len <= 16'(slen);
        end
    end

    assign result = res_reg;

endmodule

FILE: hdl/ifrt_out.sv
// Output register stage holding one result until taken.
// Depends on ifrt_pkg.
module ifrt_out
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  ifrt_pkg::result_t  res,
    output logic               busy,
    output logic               valid,
    input  logic               ready,
    output ifrt_pkg::result_t  data
);
    import ifrt_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign busy  = valid_reg && !ready;
    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

FILE: hdl/ip_fragment_reassembly_tracker_top.sv
// Top level of the IPv4 fragment reassembly tracker.
// Depends on ifrt_pkg, ifrt_if, ifrt_ctrl, ifrt_dp, ifrt_out.
//
//  channel  dir  handshake        payload
//  req      in   valid/ready      func now_time frag_id src_addr frag_word ...
//  rsp      out  valid/ready      status slot_index datagram_len unfragmented ...
//  cfg      in   cfg_we           cfg_data = timeout_ms
//
// A request goes through accept, a scan of every slot, then apply, check and
// result; errors and pass-through packets skip the scan, apply and check.
// One request is in work at a time; the output register holds a result while
// the next request is taken. Reset clears all slots, timeout_ms is 30000.
module ip_fragment_reassembly_tracker_top
#(
    parameter int unsigned MAX_DATAGRAM = 8192,
    parameter int unsigned HEADER_BYTES = 20
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_data,
    ifrt_in_if.sink      req,
    ifrt_out_if.source   rsp
);
    import ifrt_pkg::*;

    logic [31:0] timeout_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    result_t     res, out_data;
    logic        out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= 32'd30000;
        else if (cfg_we)
            timeout_reg <= cfg_data;
    end

    ifrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .out_busy (out_busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    ifrt_dp #(
        .MAX_DATAGRAM (MAX_DATAGRAM),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .timeout_ms   (timeout_reg),
        .func         (req.func),
        .now_time     (req.now_time),
        .frag_id      (req.frag_id),
        .src_addr     (req.src_addr),
        .frag_word    (req.frag_word),
        .ip_total_len (req.ip_total_len),
        .packet_len   (req.packet_len),
        .result       (res)
    );

    ifrt_out u_out
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cmd.emit),
        .res   (res),
        .busy  (out_busy),
        .valid (rsp.valid),
        .ready (rsp.ready),
        .data  (out_data)
    );

    assign rsp.status       = out_data.status;
    assign rsp.slot_index   = out_data.slot_index;
    assign rsp.datagram_len = out_data.datagram_len;
    assign rsp.unfragmented = out_data.unfragmented;
    assign rsp.reaped_count = out_data.reaped_count;

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load, cmd.scan, cmd.apply, cmd.check, cmd.emit}) <= 1)
        else $error("more than one datapath command");
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> req.ready)
        else $error("request loaded while not ready");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> rsp.valid)
        else $error("result not presented after emit");
`endif

endmodule

FILE: test/ifrt_checker.sv
// Checker for the fragment reassembly tracker: watches the request and result
// channels, predicts each result and compares it. Depends on ifrt_pkg, ifrt_if.
`timescale 1ns / 100ps
module ifrt_checker
    import ifrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    ifrt_in_if          req,
    ifrt_out_if         rsp,
    output int          fail_count,
    output int          pending_count
);

    localparam int NSLOT   = 4;
    localparam int MAXDG   = 8192;
    localparam int HDR     = 20;

    logic [31:0] age_limit;
    logic        used  [NSLOT];
    logic        done  [NSLOT];
    logic [15:0] ident [NSLOT];
    logic [31:0] source[NSLOT];
    logic [31:0] stamp [NSLOT];
    logic [31:0] chunks[NSLOT];
    logic [13:0] length[NSLOT];

    result_t expected_results[$];

    assign pending_count = expected_results.size();

    function automatic void release_slot(int s);
        used[s]   = 1'b0;
        done[s]   = 1'b0;
        chunks[s] = '0;
        length[s] = '0;
    endfunction

    function automatic result_t track_request(logic fn, logic [31:0] now, logic [15:0] id,
                                              logic [31:0] src, logic [15:0] ff,
                                              logic [15:0] total, logic [15:0] plen);
        result_t r;
        int unsigned off, l4, c_end, cnt;
        logic more, found;
        logic [31:0] best_age, age, mask;
        int s;
        r = '0;
        found = 1'b0;
        s = 0;
        if (fn == FUNC_SWEEP)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                if (used[i] && (done[i] || (now - stamp[i]) > age_limit))
                begin
                    release_slot(i);
                    r.reaped_count++;
                end
            end
            r.status = ST_PENDING;
            return r;
        end
        if (plen < HDR)
        begin
            r.status = ST_ERROR;
            return r;
        end
        off  = int'(ff[12:0]) * 8;
        more = ff[13];
        if (off == 0 && !more)
        begin
            if (total < HDR || total > plen)
            begin
                r.status = ST_ERROR;
                return r;
            end
            r.status = ST_DONE;
            r.unfragmented = 1'b1;
            r.datagram_len = 16'(total - HDR);
            return r;
        end
        if (total < HDR)
        begin
            r.status = ST_ERROR;
            return r;
        end
        l4 = total - HDR;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (!found && used[i] && !done[i] && ident[i] == id && source[i] == src)
            begin
                s = i;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            if (off != 0)
            begin
                r.status = ST_DISCARD;
                return r;
            end
            s = -1;
            for (int i = 0; i < NSLOT; i++)
                if (s < 0 && !used[i])
                    s = i;
            if (s < 0)
            begin
                s = 0;
                best_age = now - stamp[0];
                for (int i = 1; i < NSLOT; i++)
                begin
                    age = now - stamp[i];
                    if (age > best_age)
                    begin
                        best_age = age;
                        s = i;
                    end
                end
            end
            release_slot(s);
            used[s]   = 1'b1;
            stamp[s]  = now;
            ident[s]  = id;
            source[s] = src;
        end
        r.slot_index = s[1:0];
        if (off + l4 > MAXDG)
        begin
            release_slot(s);
            r.status = ST_ERROR;
            return r;
        end
        c_end = (off + l4 + 255) / 256;
        for (int unsigned c = off / 256; c < c_end && c < 32; c++)
            chunks[s][c] = 1'b1;
        if (!more)
            length[s] = 14'((off + l4) & 32'h3FFF);
        r.status = ST_PENDING;
        if (length[s] != 0)
        begin
            cnt = (int'(length[s]) + 255) / 256;
            if (cnt <= 32)
            begin
                mask = (cnt == 32) ? 32'hFFFF_FFFF : ((32'd1 << cnt) - 1);
                if ((chunks[s] & mask) == mask)
                begin
                    done[s] = 1'b1;
                    r.status = ST_DONE;
                    r.datagram_len = 16'(length[s]);
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got, want;
        if (!rst_n)
        begin
            age_limit = 32'd30000;
            for (int i = 0; i < NSLOT; i++)
            begin
                release_slot(i);
                ident[i] = '0;
                source[i] = '0;
                stamp[i] = '0;
            end
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
                age_limit = cfg_data;
            if (req.valid && req.ready)
                expected_results.push_back(track_request(req.func, req.now_time, req.frag_id,
                    req.src_addr, req.frag_word, req.ip_total_len, req.packet_len));
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.status, rsp.slot_index, rsp.datagram_len, rsp.unfragmented,
                        rsp.reaped_count};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

endmodule

FILE: test/tb.sv
// Testbench top for the fragment reassembly tracker: clock, reset, stimulus,
// configuration and verdict. Depends on ifrt_pkg, ifrt_if, ifrt_checker.
`timescale 1ns / 100ps
module tb;
    import ifrt_pkg::*;

    localparam int LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending_count;
    int          cycles;
    logic        hold_off;

    ifrt_in_if  req ();
    ifrt_out_if rsp ();

    ip_fragment_reassembly_tracker_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .req(req.sink), .rsp(rsp.source)
    );

    ifrt_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .req(req), .rsp(rsp), .fail_count(fail_count), .pending_count(pending_count)
    );

    // Clock time and a small pool of flows keep matches frequent.
    logic [31:0] clock_ms;
    logic [15:0] flow_id  [4];
    logic [31:0] flow_src [4];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side: random stall per result, plus one long hold-off.
    initial
    begin
        int w;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                rsp.ready <= 1'b0;
            else if (rsp.ready && rsp.valid)
            begin
                w = $urandom_range(0, 3);
                rsp.ready <= (w == 0);
            end
            else if (!rsp.ready)
                rsp.ready <= ($urandom_range(0, 3) == 0) || cycles > LIMIT / 2;
        end
    end

    // Valid stays high between back-to-back requests; drain() drops it.
    task automatic send(logic fn, logic [31:0] now, logic [15:0] id, logic [31:0] src,
                        logic [15:0] ff, logic [15:0] total, logic [15:0] plen,
                        bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.func         <= fn;
        req.now_time     <= now;
        req.frag_id      <= id;
        req.src_addr     <= src;
        req.frag_word    <= ff;
        req.ip_total_len <= total;
        req.packet_len   <= plen;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_timeout(logic [31:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One fragment of a flow: offset in 8-byte units, payload bytes, more flag.
    task automatic fragment(int f, int unsigned off8, int unsigned pay, bit more);
        logic [15:0] ff;
        ff = {2'b00, more, 13'(off8)};
        if ($urandom_range(0, 15) == 0)
            ff[15:14] = 2'($urandom);
        send(FUNC_FRAG, clock_ms, flow_id[f], flow_src[f], ff, 16'(pay + 20),
             16'(pay + 20 + $urandom_range(0, 3)));
    endtask

    task automatic datagram(int f);
        int unsigned total, pos, step;
        total = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8300)
                                           : $urandom_range(1, 1500);
        pos = 0;
        while (pos < total)
        begin
            step = 8 * $urandom_range(1, 200);
            if (pos + step >= total || $urandom_range(0, 9) == 0)
                step = total - pos;
            fragment(f, pos / 8, step, pos + step < total);
            pos += (step + 7) / 8 * 8;
            clock_ms += $urandom_range(0, 50);
        end
    endtask

    initial
    begin
        int f;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        hold_off = 1'b0;
        req.valid = 1'b0;
        req.func = FUNC_FRAG;
        req.now_time = '0;
        req.frag_id = '0;
        req.src_addr = '0;
        req.frag_word = '0;
        req.ip_total_len = '0;
        req.packet_len = '0;
        clock_ms = 32'hFFFF_F000;
        for (int i = 0; i < 4; i++)
        begin
            flow_id[i]  = 16'($urandom);
            flow_src[i] = $urandom;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: errors, pass-through, discard, oversize, zero payload, sweeps.
        send(FUNC_FRAG, 0, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 16'd40, 16'd19);
        send(FUNC_FRAG, 0, 0, 0, 16'h0000, 16'd19, 16'd60);
        send(FUNC_FRAG, 0, 0, 0, 16'h0000, 16'd61, 16'd60);
        send(FUNC_FRAG, 0, 0, 0, 16'h0000, 16'd20, 16'd20);
        send(FUNC_FRAG, 0, 0, 0, 16'hC000, 16'hFFFF, 16'hFFFF);
        send(FUNC_FRAG, 0, 1, 2, 16'h2000, 16'd10, 16'd40);
        send(FUNC_FRAG, 0, 1, 2, 16'h1FFF, 16'd40, 16'd40);
        send(FUNC_FRAG, 5, 1, 2, 16'h2000, 16'd20, 16'd40);
        send(FUNC_FRAG, 6, 1, 2, 16'h2020, 16'd20, 16'd40);
        send(FUNC_FRAG, 7, 1, 2, 16'h0040, 16'd276, 16'd300);
        send(FUNC_FRAG, 8, 3, 4, 16'h2000, 16'd8213, 16'hFFFF);
        for (int i = 0; i < 5; i++)
            send(FUNC_FRAG, 32'hFFFF_FFF0 + i, 16'(10 + i), 32'(i), 16'h2000, 16'd100,
                 16'd100);
        send(FUNC_FRAG, 100, 16'hFFFF, 32'hFFFF_FFFF, 16'h3FFF, 16'hFFFF, 16'hFFFF);
        send(FUNC_SWEEP, 30020, 0, 0, 0, 0, 0);
        send(FUNC_SWEEP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        write_timeout(32'd1);
        send(FUNC_FRAG, 50, 7, 7, 16'h2000, 16'd100, 16'd100);
        send(FUNC_SWEEP, 51, 0, 0, 0, 0, 0);
        send(FUNC_SWEEP, 52, 0, 0, 0, 0, 0);
        write_timeout(32'hFFFF_FFFF);
        send(FUNC_FRAG, 60, 7, 7, 16'h2000, 16'd100, 16'd100);
        send(FUNC_SWEEP, 59, 0, 0, 0, 0, 0);

        // Long result hold-off while requests keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send(FUNC_FRAG, 32'(i), 16'($urandom), $urandom, 16'($urandom),
                     16'($urandom), 16'($urandom), 1);
        join

        // Random phases across several timeout settings.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_timeout(32'd30000);
                1: write_timeout(32'd1);
                2: write_timeout($urandom_range(20, 400));
                3: write_timeout(32'hFFFF_FFFF);
                default: write_timeout($urandom);
            endcase
            for (int n = 0; n < 195; n++)
            begin
                f = $urandom_range(0, 3);
                case ($urandom_range(0, 9))
                    0: send(FUNC_SWEEP, clock_ms, 16'($urandom), $urandom, 16'($urandom),
                            16'($urandom), 16'($urandom));
                    1: send(FUNC_FRAG, $urandom, 16'($urandom), $urandom, 16'($urandom),
                            16'($urandom), 16'($urandom));
                    2: begin
                        flow_id[f]  = 16'($urandom);
                        flow_src[f] = ($urandom_range(0, 1)) ? flow_src[f] : $urandom;
                        fragment(f, $urandom_range(0, 1100), $urandom_range(0, 900),
                                 $urandom_range(0, 1));
                    end
                    default: begin
                        flow_id[f] = 16'($urandom);
                        datagram(f);
                    end
                endcase
                clock_ms += $urandom_range(0, 200);
            end
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
